>>> design/assert_macros.svh
// Assertion macros shared by the encoder RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// The condition must hold on every cycle out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)

`endif

`endif

>>> design/xse_pkg.sv
// Package for the x86 subset encoder: opcode and operand kind codes,
// fixed encoding bytes, and the structs passed between the modules. No dependencies.
`timescale 1ns / 1ps

package xse_pkg;

  localparam int unsigned CODE_W = 48;
  localparam int unsigned CNT_W  = 3;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_CALL = 4'd1,
    OP_CMP  = 4'd2,
    OP_JE   = 4'd3,
    OP_JMP  = 4'd4,
    OP_MOV  = 4'd5,
    OP_POP  = 4'd6,
    OP_PUSH = 4'd7,
    OP_RET  = 4'd8
  } opcode_t;

  typedef enum logic [1:0] {
    OPND_NONE = 2'd0,
    OPND_REG  = 2'd1,
    OPND_IMM  = 2'd2,
    OPND_OFF  = 2'd3
  } opnd_t;

  // Fixed opcode and prefix bytes.
  localparam logic [7:0] BYTE_REX_W   = 8'h48;
  localparam logic [7:0] BYTE_REX_B   = 8'h41;
  localparam logic [7:0] BYTE_ADD_RR  = 8'h01;
  localparam logic [7:0] BYTE_GRP1_I8 = 8'h83;
  localparam logic [7:0] BYTE_CALL    = 8'he8;
  localparam logic [7:0] BYTE_JE8     = 8'h74;
  localparam logic [7:0] BYTE_JMP8    = 8'heb;
  localparam logic [7:0] BYTE_MOV_RI  = 8'hb8;
  localparam logic [7:0] BYTE_MOV_RR  = 8'h89;
  localparam logic [7:0] BYTE_POP     = 8'h58;
  localparam logic [7:0] BYTE_PUSH    = 8'h50;
  localparam logic [7:0] BYTE_RET     = 8'hc3;

  // ModRM reg-field extensions of the 0x83 group.
  localparam logic [2:0] EXT_ADD = 3'd0;
  localparam logic [2:0] EXT_CMP = 3'd7;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  first_type;
    logic [1:0]  second_type;
    logic [3:0]  first_reg;
    logic [3:0]  second_reg;
    logic [31:0] immediate;
    logic [31:0] offset;
  } enc_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_bytes;
    logic [CNT_W-1:0]  byte_count;
    logic              bad_form;
  } enc_out_t;

endpackage

>>> design/xse_encoder.sv
// Combinational x86-64 byte encoder for one instruction.
// Depends on xse_pkg for opcode codes, fixed bytes and the item structs.
`timescale 1ns / 1ps

module xse_encoder (
  input  xse_pkg::enc_in_t  item,
  output xse_pkg::enc_out_t result
);
  import xse_pkg::*;

  opcode_t     op;
  opnd_t       t0;
  opnd_t       t1;
  logic [7:0]  imm8;
  logic [7:0]  rex_rr;
  logic [7:0]  rex_ri;
  logic [7:0]  modrm_rr;
  logic [31:0] rel32;
  logic [7:0]  rel8;
  logic [7:0]  reg_op;

  assign op     = opcode_t'(item.kind);
  assign t0     = opnd_t'(item.first_type);
  assign t1     = opnd_t'(item.second_type);
  assign imm8   = item.immediate[7:0];
  assign rex_rr = BYTE_REX_W | {5'b0, item.second_reg[3], 1'b0, item.first_reg[3]};
  assign rex_ri = BYTE_REX_W | {7'b0, item.first_reg[3]};
  assign modrm_rr = {2'b11, item.second_reg[2:0], item.first_reg[2:0]};
  assign rel32  = item.offset - 32'd5;
  assign rel8   = item.offset[7:0] - 8'd2;

  // Opcode byte of the short forms that carry the register in the low bits.
  always_comb begin
    case (op)
      OP_MOV:  reg_op = BYTE_MOV_RI | {5'b0, item.first_reg[2:0]};
      OP_POP:  reg_op = BYTE_POP | {5'b0, item.first_reg[2:0]};
      default: reg_op = BYTE_PUSH | {5'b0, item.first_reg[2:0]};
    endcase
  end

  always_comb begin
    result.code_bytes = '0;
    result.byte_count = '0;
    result.bad_form   = 1'b1;
    unique case (op)
      OP_ADD, OP_CMP: begin
        if (op == OP_ADD && t0 == OPND_REG && t1 == OPND_REG) begin
          result.code_bytes = {24'b0, modrm_rr, BYTE_ADD_RR, rex_rr};
          result.byte_count = 3'd3;
          result.bad_form   = 1'b0;
        end else if (t0 == OPND_REG && t1 == OPND_IMM && !imm8[7]) begin
          result.code_bytes = {16'b0, imm8,
                               2'b11, (op == OP_ADD) ? EXT_ADD : EXT_CMP,
                               item.first_reg[2:0], BYTE_GRP1_I8, rex_ri};
          result.byte_count = 3'd4;
          result.bad_form   = 1'b0;
        end
      end
      OP_CALL: begin
        if (t0 == OPND_OFF) begin
          result.code_bytes = {8'b0, rel32, BYTE_CALL};
          result.byte_count = 3'd5;
          result.bad_form   = 1'b0;
        end
      end
      OP_JE, OP_JMP: begin
        if (t0 == OPND_OFF) begin
          result.code_bytes = {32'b0, rel8, (op == OP_JE) ? BYTE_JE8 : BYTE_JMP8};
          result.byte_count = 3'd2;
          result.bad_form   = 1'b0;
        end
      end
      OP_MOV: begin
        if (t0 == OPND_REG && t1 == OPND_IMM) begin
          if (item.first_reg[3]) begin
            result.code_bytes = {item.immediate, reg_op, BYTE_REX_B};
            result.byte_count = 3'd6;
          end else begin
            result.code_bytes = {8'b0, item.immediate, reg_op};
            result.byte_count = 3'd5;
          end
          result.bad_form = 1'b0;
        end else if (t0 == OPND_REG && t1 == OPND_REG) begin
          result.code_bytes = {24'b0, modrm_rr, BYTE_MOV_RR, rex_rr};
          result.byte_count = 3'd3;
          result.bad_form   = 1'b0;
        end
      end
      OP_POP, OP_PUSH: begin
        if (t0 == OPND_REG) begin
          if (item.first_reg[3]) begin
            result.code_bytes = {32'b0, reg_op, BYTE_REX_B};
            result.byte_count = 3'd2;
          end else begin
            result.code_bytes = {40'b0, reg_op};
            result.byte_count = 3'd1;
          end
          result.bad_form = 1'b0;
        end
      end
      OP_RET: begin
        if (t0 == OPND_NONE) begin
          result.code_bytes = {40'b0, BYTE_RET};
          result.byte_count = 3'd1;
          result.bad_form   = 1'b0;
        end
      end
      default: begin
        result.bad_form = 1'b1;
      end
    endcase
  end

endmodule

>>> design/x86_subset_instruction_encoder.sv
// Top level of the x86-64 subset instruction encoder.
// Depends on xse_pkg, xse_encoder and assert_macros.svh.
`timescale 1ns / 1ps

// Usage:
// An instruction item is offered on kind, first_type, second_type, first_reg,
// second_reg, immediate and offset, and is taken at the rising clock edge
// where start is high and busy is low. Busy is always low in this design, so
// a new item can be taken on every cycle.
// Each item is captured in an input register, encoded by one pass of
// combinational logic, and captured in a result register. Its result appears
// on code_bytes, byte_count and bad_form for exactly one cycle, marked by
// done, once the item has passed the input register and the result register;
// it is accepted at the edge that ends that done cycle. Results come out in
// the order the items went in, one per item.
// Throughput is one item per cycle.
// The receiver cannot stall: a result is accepted on the edge that ends
// its done cycle.
// An instruction that cannot be encoded gives bad_form high, byte_count zero
// and code_bytes zero.
// Synchronous reset drops any items in flight; done is low after reset.

module x86_subset_instruction_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  kind,
  input  logic [1:0]  first_type,
  input  logic [1:0]  second_type,
  input  logic [3:0]  first_reg,
  input  logic [3:0]  second_reg,
  input  logic [31:0] immediate,
  input  logic signed [31:0] offset,
  output logic        done,
  output logic [xse_pkg::CODE_W-1:0] code_bytes,
  output logic [xse_pkg::CNT_W-1:0]  byte_count,
  output logic        bad_form
);
  import xse_pkg::*;

`include "assert_macros.svh"

  // The encoder has no state, so the block never needs to hold off an item.
  assign busy = 1'b0;

  logic     stage_valid;
  enc_in_t  stage_item;
  enc_out_t enc_result;
  enc_out_t result_reg;

  // Input register: control bit is reset, payload is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      stage_item <= '{kind:        kind,
                      first_type:  first_type,
                      second_type: second_type,
                      first_reg:   first_reg,
                      second_reg:  second_reg,
                      immediate:   immediate,
                      offset:      offset};
    end
  end

  xse_encoder u_encoder (
    .item   (stage_item),
    .result (enc_result)
  );

  // Result register: the strobe is reset, the payload is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid) begin
      result_reg <= enc_result;
    end
  end

  assign code_bytes = result_reg.code_bytes;
  assign byte_count = result_reg.byte_count;
  assign bad_form   = result_reg.bad_form;

  // Every accepted item reaches the encoder stage on the next cycle.
  `ASSERT_NEXT(a_issue, clk, rst, start && !busy, stage_valid)
  // Every item in the encoder stage is delivered on the next cycle.
  `ASSERT_NEXT(a_deliver, clk, rst, stage_valid, done)
  // An error result carries no bytes.
  `ASSERT_IMPLIES(a_bad_empty, clk, rst, done && bad_form,
                  byte_count == '0 && code_bytes == '0)
  // A good result carries at least one and at most six bytes.
  `ASSERT_IMPLIES(a_good_count, clk, rst, done && !bad_form,
                  byte_count != '0 && byte_count <= 3'd6)
  // The block never refuses an item.
  `ASSERT_ALWAYS(a_never_busy, clk, rst, !busy)

endmodule

>>> bench/tb_top.sv
// Self-checking bench for x86_subset_instruction_encoder: directed and random instructions,
// each expected encoding predicted in a scoreboard class and compared with the result port.
// Depends on xse_pkg for the opcode and operand kind codes, widths and structs, and on the encoder.
`timescale 1ns / 1ps

module tb_top;
  import xse_pkg::*;

  // Encoding bytes, kept apart from the package so that a wrong package constant shows up.
  localparam logic [7:0] OPC_REX_W    = 8'h48;
  localparam logic [7:0] OPC_REX_B    = 8'h41;
  localparam logic [7:0] OPC_ADD_RR   = 8'h01;
  localparam logic [7:0] OPC_ALU_IMM8 = 8'h83;
  localparam logic [7:0] OPC_CALL     = 8'he8;
  localparam logic [7:0] OPC_JE_REL8  = 8'h74;
  localparam logic [7:0] OPC_JMP_REL8 = 8'heb;
  localparam logic [7:0] OPC_MOV_IMM  = 8'hb8;
  localparam logic [7:0] OPC_MOV_RR   = 8'h89;
  localparam logic [7:0] OPC_POP      = 8'h58;
  localparam logic [7:0] OPC_PUSH     = 8'h50;
  localparam logic [7:0] OPC_RET      = 8'hc3;
  localparam logic [2:0] GRP_ADD      = 3'd0;
  localparam logic [2:0] GRP_CMP      = 3'd7;
  // The range of opcode values that no instruction uses.
  localparam logic [3:0] KIND_FIRST_BAD = 4'd9;
  localparam logic [3:0] KIND_LAST_BAD  = 4'd15;

  localparam int unsigned ITEMS_PER_PHASE = 270;

  // Scoreboard: predicts the encoding of every accepted item and checks the results in order.
  class encoding_scoreboard;
    enc_out_t    pending_encodings[$];
    int unsigned mismatches;
    logic [47:0] acc;
    int unsigned acc_n;

    function void emit(logic [7:0] b);
      acc = acc | (48'(b) << (8 * acc_n));
      acc_n++;
    endfunction

    function logic [7:0] rex(logic r_hi, logic b_hi);
      return OPC_REX_W | {5'b0, r_hi, 1'b0, b_hi};
    endfunction

    function logic [7:0] modrm(logic [2:0] reg_field, logic [2:0] rm_field);
      return {2'b11, reg_field, rm_field};
    endfunction

    function enc_out_t encode_instruction(enc_in_t it);
      logic        bad;
      logic [31:0] rel;
      logic        reg_reg;
      logic        reg_imm;
      enc_out_t    r;
      acc     = '0;
      acc_n   = 0;
      bad     = 1'b0;
      reg_reg = (it.first_type == OPND_REG) && (it.second_type == OPND_REG);
      reg_imm = (it.first_type == OPND_REG) && (it.second_type == OPND_IMM);
      case (it.kind)
        OP_ADD: begin
          if (reg_reg) begin
            emit(rex(it.second_reg[3], it.first_reg[3]));
            emit(OPC_ADD_RR);
            emit(modrm(it.second_reg[2:0], it.first_reg[2:0]));
          end else if (reg_imm && !it.immediate[7]) begin
            emit(rex(1'b0, it.first_reg[3]));
            emit(OPC_ALU_IMM8);
            emit(modrm(GRP_ADD, it.first_reg[2:0]));
            emit(it.immediate[7:0]);
          end else begin
            bad = 1'b1;
          end
        end
        OP_CMP: begin
          if (reg_imm && !it.immediate[7]) begin
            emit(rex(1'b0, it.first_reg[3]));
            emit(OPC_ALU_IMM8);
            emit(modrm(GRP_CMP, it.first_reg[2:0]));
            emit(it.immediate[7:0]);
          end else begin
            bad = 1'b1;
          end
        end
        OP_CALL: begin
          if (it.first_type == OPND_OFF) begin
            rel = it.offset - 32'd5;
            emit(OPC_CALL);
            emit(rel[7:0]);
            emit(rel[15:8]);
            emit(rel[23:16]);
            emit(rel[31:24]);
          end else begin
            bad = 1'b1;
          end
        end
        OP_JE, OP_JMP: begin
          if (it.first_type == OPND_OFF) begin
            rel = it.offset - 32'd2;
            emit(it.kind == OP_JE ? OPC_JE_REL8 : OPC_JMP_REL8);
            emit(rel[7:0]);
          end else begin
            bad = 1'b1;
          end
        end
        OP_MOV: begin
          if (reg_imm) begin
            if (it.first_reg[3]) emit(OPC_REX_B);
            emit(OPC_MOV_IMM + {5'b0, it.first_reg[2:0]});
            emit(it.immediate[7:0]);
            emit(it.immediate[15:8]);
            emit(it.immediate[23:16]);
            emit(it.immediate[31:24]);
          end else if (reg_reg) begin
            emit(rex(it.second_reg[3], it.first_reg[3]));
            emit(OPC_MOV_RR);
            emit(modrm(it.second_reg[2:0], it.first_reg[2:0]));
          end else begin
            bad = 1'b1;
          end
        end
        OP_POP, OP_PUSH: begin
          if (it.first_type == OPND_REG) begin
            if (it.first_reg[3]) emit(OPC_REX_B);
            emit((it.kind == OP_POP ? OPC_POP : OPC_PUSH) + {5'b0, it.first_reg[2:0]});
          end else begin
            bad = 1'b1;
          end
        end
        OP_RET: begin
          if (it.first_type == OPND_NONE) emit(OPC_RET);
          else bad = 1'b1;
        end
        default: begin
          bad = 1'b1;
        end
      endcase
      if (bad) begin
        acc   = '0;
        acc_n = 0;
      end
      r.code_bytes = acc;
      r.byte_count = 3'(acc_n);
      r.bad_form   = bad;
      return r;
    endfunction

    function void note_instruction(enc_in_t it);
      pending_encodings.push_back(encode_instruction(it));
    endfunction

    function void report(string what, logic [47:0] want, logic [47:0] got);
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    endfunction

    function void check_encoding(enc_out_t got);
      enc_out_t want;
      if (pending_encodings.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual %h/%0d/%b", $time,
                 got.code_bytes, got.byte_count, got.bad_form);
        return;
      end
      want = pending_encodings.pop_front();
      if (got.code_bytes !== want.code_bytes)
        report("code_bytes", want.code_bytes, got.code_bytes);
      if (got.byte_count !== want.byte_count)
        report("byte_count", 48'(want.byte_count), 48'(got.byte_count));
      if (got.bad_form !== want.bad_form)
        report("bad_form", 48'(want.bad_form), 48'(got.bad_form));
    endfunction

    function int unsigned pending();
      return pending_encodings.size();
    endfunction
  endclass

  // Every input starts at a known value; rst is high until the bench releases it.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [3:0]         kind = '0;
  logic [1:0]         first_type = '0;
  logic [1:0]         second_type = '0;
  logic [3:0]         first_reg = '0;
  logic [3:0]         second_reg = '0;
  logic [31:0]        immediate = '0;
  logic signed [31:0] offset = '0;
  logic               busy;
  logic               done;
  logic [CODE_W-1:0]  code_bytes;
  logic [CNT_W-1:0]   byte_count;
  logic               bad_form;

  encoding_scoreboard sb = new();

  x86_subset_instruction_encoder u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .first_type(first_type), .second_type(second_type),
    .first_reg(first_reg), .second_reg(second_reg),
    .immediate(immediate), .offset(offset),
    .done(done), .code_bytes(code_bytes), .byte_count(byte_count), .bad_form(bad_form)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Both monitors sample at the rising edge, before any nonblocking update of that edge lands,
  // so they see exactly what the block sees.
  always @(posedge clk) begin
    if (!rst && start && busy === 1'b0)
      sb.note_instruction('{kind, first_type, second_type, first_reg, second_reg,
                            immediate, offset});
  end

  // The receiver cannot hold results off, so every done cycle is an accepted result.
  always @(posedge clk) begin
    if (!rst && done === 1'b1)
      sb.check_encoding('{code_bytes, byte_count, bad_form});
  end

  function automatic enc_in_t mk(logic [3:0] k, logic [1:0] t0, logic [1:0] t1,
                                 logic [3:0] r0, logic [3:0] r1,
                                 logic [31:0] imm, logic [31:0] off);
    enc_in_t it;
    it = '{k, t0, t1, r0, r1, imm, off};
    return it;
  endfunction

  // Random instructions: most are well formed with random content so that every encoding
  // form is exercised; the rest carry random operand kinds or unused opcodes.
  function automatic enc_in_t random_instruction();
    enc_in_t     it;
    int unsigned pick;
    it.kind        = 4'($urandom_range(8, 0));
    it.first_type  = 2'($urandom);
    it.second_type = 2'($urandom);
    it.first_reg   = 4'($urandom);
    it.second_reg  = 4'($urandom);
    it.immediate   = $urandom;
    it.offset      = $urandom;
    // Short branches near zero make the rel8 wrap around the signed limits likely.
    if ($urandom_range(3, 0) == 0) it.offset = 32'($urandom_range(300, 0)) - 32'd150;
    pick = $urandom_range(99, 0);
    if (pick < 85) begin
      case (it.kind)
        OP_ADD: begin
          it.first_type  = OPND_REG;
          it.second_type = $urandom_range(1, 0) ? OPND_REG : OPND_IMM;
        end
        OP_CMP: begin
          it.first_type  = OPND_REG;
          it.second_type = OPND_IMM;
        end
        OP_CALL, OP_JE, OP_JMP: it.first_type = OPND_OFF;
        OP_MOV: begin
          it.first_type  = OPND_REG;
          it.second_type = $urandom_range(1, 0) ? OPND_REG : OPND_IMM;
        end
        OP_POP, OP_PUSH: it.first_type = OPND_REG;
        default: it.first_type = OPND_NONE;
      endcase
      // Keep most 8-bit immediates encodable; the rest may hit the too-big error.
      if ((it.kind == OP_ADD || it.kind == OP_CMP) && $urandom_range(3, 0) != 0)
        it.immediate[7] = 1'b0;
    end else if (pick < 93) begin
      it.kind = 4'($urandom_range(15, 0));
    end
    return it;
  endfunction

  // Offers one item and returns at the edge that takes it; start stays high.
  task automatic send_instruction(input enc_in_t it);
    start       <= 1'b1;
    kind        <= it.kind;
    first_type  <= it.first_type;
    second_type <= it.second_type;
    first_reg   <= it.first_reg;
    second_reg  <= it.second_reg;
    immediate   <= it.immediate;
    offset      <= it.offset;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Sends an item, then leaves the input idle in each following cycle with the given
  // chance in percent, so that about that share of all cycles is idle.
  task automatic send_then_idle(input enc_in_t it, input int unsigned idle_pct);
    send_instruction(it);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Holds the sender off until every expected encoding has come back, with a bound.
  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic random_phase(input int unsigned idle_pct);
    for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
      send_then_idle(random_instruction(), idle_pct);
      // Now and then the sender waits for the pipeline to empty completely.
      if ($urandom_range(99, 0) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    // Reset is held from the start, released once, and never asserted again.
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: register extremes, every opcode, wrap of the displacements,
    // the 8-bit immediate limit, invalid opcodes and operand kinds that no form accepts.
    send_then_idle(mk(OP_ADD,  OPND_REG, OPND_REG, 4'd0, 4'd15, '0, '0), 12);
    send_then_idle(mk(OP_ADD,  OPND_REG, OPND_REG, 4'd15, 4'd0, '1, '1), 12);
    send_then_idle(mk(OP_ADD,  OPND_REG, OPND_IMM, 4'd8, 4'd3, 32'd127, '0), 12);
    send_then_idle(mk(OP_ADD,  OPND_REG, OPND_IMM, 4'd2, 4'd0, 32'd128, '0), 12);
    send_then_idle(mk(OP_ADD,  OPND_REG, OPND_IMM, 4'd7, 4'd0, 32'hffffff7f, '0), 12);
    send_then_idle(mk(OP_CMP,  OPND_REG, OPND_IMM, 4'd15, 4'd9, 32'd0, '0), 12);
    send_then_idle(mk(OP_CMP,  OPND_REG, OPND_IMM, 4'd0, 4'd0, 32'h80, '0), 12);
    send_then_idle(mk(OP_CMP,  OPND_REG, OPND_REG, 4'd1, 4'd2, 32'd5, '0), 12);
    send_then_idle(mk(OP_CALL, OPND_OFF, OPND_NONE, '0, '0, '0, 32'd0), 12);
    send_then_idle(mk(OP_CALL, OPND_OFF, OPND_REG, '0, '0, '0, 32'h80000000), 12);
    send_then_idle(mk(OP_CALL, OPND_OFF, OPND_IMM, '0, '0, '0, 32'h7fffffff), 12);
    send_then_idle(mk(OP_CALL, OPND_REG, OPND_NONE, '0, '0, '0, 32'd10), 12);
    send_then_idle(mk(OP_JE,   OPND_OFF, OPND_NONE, '0, '0, '0, 32'h81), 12);
    send_then_idle(mk(OP_JE,   OPND_OFF, OPND_OFF, '0, '0, '0, 32'd1), 12);
    send_then_idle(mk(OP_JMP,  OPND_OFF, OPND_NONE, '0, '0, '0, 32'hffffffff), 12);
    send_then_idle(mk(OP_JMP,  OPND_IMM, OPND_NONE, '0, '0, '0, 32'd4), 12);
    send_then_idle(mk(OP_MOV,  OPND_REG, OPND_IMM, 4'd0, 4'd0, 32'hffffffff, '0), 12);
    send_then_idle(mk(OP_MOV,  OPND_REG, OPND_IMM, 4'd15, 4'd0, 32'h12345678, '0), 12);
    send_then_idle(mk(OP_MOV,  OPND_REG, OPND_REG, 4'd8, 4'd9, '0, '0), 12);
    send_then_idle(mk(OP_MOV,  OPND_REG, OPND_NONE, 4'd3, 4'd3, '0, '0), 12);
    send_then_idle(mk(OP_POP,  OPND_REG, OPND_NONE, 4'd0, '0, '0, '0), 12);
    send_then_idle(mk(OP_POP,  OPND_REG, OPND_IMM, 4'd15, '0, '0, '0), 12);
    send_then_idle(mk(OP_PUSH, OPND_REG, OPND_NONE, 4'd7, '0, '0, '0), 12);
    send_then_idle(mk(OP_PUSH, OPND_REG, OPND_OFF, 4'd8, '0, '0, '0), 12);
    send_then_idle(mk(OP_RET,  OPND_NONE, OPND_REG, '0, '0, '0, '0), 12);
    send_then_idle(mk(OP_RET,  OPND_REG, OPND_NONE, '0, '0, '0, '0), 12);
    send_then_idle(mk(KIND_FIRST_BAD, OPND_REG, OPND_REG, '0, '0, '0, '0), 12);
    send_then_idle(mk(KIND_LAST_BAD, OPND_NONE, OPND_NONE, '0, '0, '0, '0), 12);
    drain_results();

    // Random part in three idling regimes: light, heavy, and back to back.
    random_phase(12);
    random_phase(61);
    random_phase(0);

    // An extra wait after the last drain covers anything stray.
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
